@@ sv/fikd_pkg.sv @@
// Package for the finger IK position-to-duty block: widths, operation codes,
// the shared serial unit's request/response types and the CORDIC angle table.
// No dependencies.
package fikd_pkg;

   localparam int FIKD_COORD_FRAC_BITS = 8;
   localparam int FIKD_CORDIC_STEPS    = 16;

   // serial unit operand widths
   localparam int OPA_W = 82;
   localparam int OPB_W = 48;
   localparam int QUO_W = 20;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic [2:0] REG_BASE_LEN   = 3'd0;
   localparam logic [2:0] REG_MIDDLE_LEN = 3'd1;
   localparam logic [2:0] REG_TIP_LEN    = 3'd2;
   localparam logic [2:0] REG_GAIN       = 3'd3;
   localparam logic [2:0] REG_GEAR       = 3'd4;

   localparam logic [6:0]  RST_BASE_LEN   = 7'd40;
   localparam logic [6:0]  RST_MIDDLE_LEN = 7'd60;
   localparam logic [6:0]  RST_TIP_LEN    = 7'd40;
   localparam logic [15:0] RST_GAIN       = 16'd256;
   localparam logic [15:0] RST_GEAR       = 16'd384;

   localparam logic [15:0] DUTY_LIMIT  = 16'd25600;
   localparam logic [17:0] DUTY_FACTOR = 18'd200000;

   typedef struct packed {
      logic             start;
      logic [1:0]       op;
      logic [4:0]       n;
      logic [OPA_W-1:0] opa;
      logic [OPB_W-1:0] opb;
   } fikd_op_req_type;

   typedef struct packed {
      logic             done;
      logic             ovf;
      logic [OPA_W-1:0] prod;
      logic [QUO_W-1:0] quo;
   } fikd_op_rsp_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [21:0] fikd_atan_deg(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/fikd_serial_unit.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and digit-by-digit square root, one bit (or bit pair) per cycle.
// Depends on fikd_pkg.
module fikd_serial_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  fikd_pkg::fikd_op_req_type req,
   output fikd_pkg::fikd_op_rsp_type rsp
);
   import fikd_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [1:0]       op_ff, op_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [OPA_W-1:0] acc_ff, acc_in;
   logic [OPA_W-1:0] mc_ff, mc_in;
   logic [17:0]      mp_ff, mp_in;
   logic [OPB_W-1:0] rem_ff, rem_in;
   logic [OPB_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   logic [OPA_W-1:0] opa_hi;
   logic [OPB_W:0]   dtrial;
   logic [22:0]      strial;
   logic [22:0]      sref;

   assign opa_hi = req.opa >> req.n;
   assign dtrial = {rem_ff, mc_ff[OPA_W-1]};
   assign strial = {rem_ff[20:0], mc_ff[OPA_W-1:OPA_W-2]};
   assign sref   = {1'b0, quo_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = req.n;
         acc_in  = '0;
         mp_in   = req.opb[17:0];
         dvs_in  = req.opb;
         quo_in  = '0;
         ovf_in  = 1'b0;
         rem_in  = '0;
         case (req.op)
            OP_MUL: begin
               mc_in = req.opa;
            end
            OP_DIV: begin
               // quotient wider than n bits means overflow
               mc_in  = req.opa << (7'(OPA_W) - {2'b00, req.n});
               rem_in = opa_hi[OPB_W-1:0];
               ovf_in = opa_hi >= {{(OPA_W-OPB_W){1'b0}}, req.opb};
            end
            OP_SQRT: begin
               mc_in = req.opa << (OPA_W - 40);
            end
            default: begin
               mc_in = req.opa;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            OP_MUL: begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = mc_ff << 1;
               mp_in = mp_ff >> 1;
            end
            OP_DIV: begin
               mc_in = mc_ff << 1;
               if (dtrial >= {1'b0, dvs_ff}) begin
                  rem_in = OPB_W'(dtrial - {1'b0, dvs_ff});
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = dtrial[OPB_W-1:0];
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
            end
            OP_SQRT: begin
               mc_in = mc_ff << 2;
               if (strial >= sref) begin
                  rem_in = OPB_W'(strial - sref);
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = OPB_W'(strial);
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.prod = acc_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ sv/finger_ik_position_to_duty.sv @@
// Top level of the finger IK position-to-duty block: sequencer, CORDIC,
// configuration registers and output register.
// Depends on fikd_pkg and fikd_serial_unit.
//
// Input transactions (req_*) carry a target x,y, a timestamp and the encoder
// angle; each gives exactly one result transaction (rsp_*) with the duty and
// three flags. Both channels use valid/ready.
// One item at a time: req_ready is high only while the sequencer is idle.
// The time from acceptance to the result is set by the single shared
// bit-serial multiply/divide/sqrt unit, each operation going through an
// issue and a wait state, and by the one-step-per-cycle CORDIC run twice.
// The result sits in an output register; the next item is taken the cycle
// after it is loaded, so a stalled receiver only holds the sequencer at the
// very end of the following item.
// Reset (synchronous, active high) returns the registers to their default
// values, clears the stored timestamp and drops the result valid.
// Configuration is an APB-style port, registers at 4*index, pready tied high.
module finger_ik_position_to_duty #(
   parameter int COORD_FRAC_BITS = fikd_pkg::FIKD_COORD_FRAC_BITS,
   parameter int CORDIC_STEPS    = fikd_pkg::FIKD_CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic [31:0]        req_stamp_us,
   input  logic signed [31:0] req_encoder_deg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_duty_q8,
   output logic               rsp_duty_saturated,
   output logic               rsp_bad_interval,
   output logic               rsp_reach_clamped,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import fikd_pkg::*;

   localparam int CIW = $clog2(CORDIC_STEPS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ISSUE  = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_CORDIC = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [4:0] SP_XX    = 5'd0;
   localparam logic [4:0] SP_YY    = 5'd1;
   localparam logic [4:0] SP_L1    = 5'd2;
   localparam logic [4:0] SP_L2    = 5'd3;
   localparam logic [4:0] SP_L3    = 5'd4;
   localparam logic [4:0] SP_DEN   = 5'd5;
   localparam logic [4:0] SP_CDIV  = 5'd6;
   localparam logic [4:0] SP_CC    = 5'd7;
   localparam logic [4:0] SP_SQS   = 5'd8;
   localparam logic [4:0] SP_K1    = 5'd9;
   localparam logic [4:0] SP_K2    = 5'd10;
   localparam logic [4:0] SP_SQR   = 5'd11;
   localparam logic [4:0] SP_ANG1  = 5'd12;
   localparam logic [4:0] SP_ANG2  = 5'd13;
   localparam logic [4:0] SP_GEAR  = 5'd14;
   localparam logic [4:0] SP_GAIN  = 5'd15;
   localparam logic [4:0] SP_SCALE = 5'd16;
   localparam logic [4:0] SP_DDIV  = 5'd17;

   // configuration
   logic [6:0]  base_len_ff, middle_len_ff, tip_len_ff;
   logic [15:0] gain_ff, gear_ff;
   logic        cfg_wr;

   // control
   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] last_stamp_ff;

   // item and working registers
   logic signed [15:0] x_ff, y_ff;
   logic signed [31:0] enc_ff;
   logic [31:0]        dtm_ff;
   logic               bad_ff;
   logic signed [41:0] num_ff, num_in;
   logic [39:0]        rarg_ff, rarg_in;
   logic [39:0]        sarg_ff, sarg_in;
   logic [47:0]        den_ff, den_in;
   logic [16:0]        cmag_ff, cmag_in;
   logic               cneg_ff, cneg_in;
   logic               reach_ff, reach_in;
   logic [16:0]        s_ff, s_in;
   logic signed [24:0] k1_ff, k1_in;
   logic [23:0]        k2_ff, k2_in;
   logic [19:0]        r_ff, r_in;
   logic signed [25:0] z1_ff, z1_in;
   logic signed [26:0] theta_ff, theta_in;
   logic signed [48:0] e_ff, e_in;

   // CORDIC
   logic signed [43:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] cz_ff, cz_in;
   logic [CIW-1:0]     ci_ff, ci_in;
   logic               czero_ff, czero_in;
   logic signed [43:0] sh_x, sh_y, xs0, ys0;
   logic signed [25:0] tab, cin_x, z_fin;
   logic [24:0]        cin_y;

   // output register
   logic signed [15:0] duty_ff, duty_in;
   logic               sat_ff, sat_in, badout_ff, badout_in, reachout_ff, reachout_in;

   // helpers
   logic [6:0]          l1e, l2e, l3e;
   logic [16:0]         xs17, ys17, absx, absy;
   logic [41:0]         absnum;
   logic [26:0]         abstheta;
   logic [48:0]         abse;
   logic [41:0]         sq_shift;
   logic [16:0]         q17;
   logic                c_over;
   logic signed [24:0]  kp;
   logic signed [42:0]  tp;
   logic signed [34:0]  thm;
   logic [15:0]         q16, dmag;
   logic                dsat;
   fikd_op_req_type     unit_req;
   fikd_op_rsp_type     unit_rsp;

   fikd_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff   <= RST_BASE_LEN;
         middle_len_ff <= RST_MIDDLE_LEN;
         tip_len_ff    <= RST_TIP_LEN;
         gain_ff       <= RST_GAIN;
         gear_ff       <= RST_GEAR;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            REG_BASE_LEN:   base_len_ff   <= pwdata[6:0];
            REG_MIDDLE_LEN: middle_len_ff <= pwdata[6:0];
            REG_TIP_LEN:    tip_len_ff    <= pwdata[6:0];
            REG_GAIN:       gain_ff       <= pwdata[15:0];
            REG_GEAR:       gear_ff       <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_BASE_LEN:   prdata = {25'd0, base_len_ff};
         REG_MIDDLE_LEN: prdata = {25'd0, middle_len_ff};
         REG_TIP_LEN:    prdata = {25'd0, tip_len_ff};
         REG_GAIN:       prdata = {16'd0, gain_ff};
         REG_GEAR:       prdata = {16'd0, gear_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // ---------------- operand helpers ----------------
   // a zero length behaves as one
   assign l1e = (base_len_ff == 7'd0)   ? 7'd1 : base_len_ff;
   assign l2e = (middle_len_ff == 7'd0) ? 7'd1 : middle_len_ff;
   assign l3e = (tip_len_ff == 7'd0)    ? 7'd1 : tip_len_ff;

   assign xs17     = {x_ff[15], x_ff};
   assign ys17     = {y_ff[15], y_ff};
   assign absx     = x_ff[15] ? (~xs17 + 17'd1) : xs17;
   assign absy     = y_ff[15] ? (~ys17 + 17'd1) : ys17;
   assign absnum   = num_ff[41] ? (42'd0 - num_ff) : num_ff;
   assign abstheta = theta_ff[26] ? (27'd0 - theta_ff) : theta_ff;
   assign abse     = e_ff[48] ? (49'd0 - e_ff) : e_ff;
   assign sq_shift = 42'(unit_rsp.prod[13:0]) << (2 * COORD_FRAC_BITS);

   assign q17    = unit_rsp.quo[16:0];
   assign c_over = unit_rsp.ovf || (q17 > 17'd65536);
   assign kp     = {2'b00, unit_rsp.prod[22:0]};
   assign tp     = theta_ff[26] ? (43'd0 - {2'b00, unit_rsp.prod[40:0]})
                                : {2'b00, unit_rsp.prod[40:0]};
   assign thm    = tp[42:8];

   assign q16  = unit_rsp.quo[15:0];
   assign dsat = unit_rsp.ovf || (q16 > DUTY_LIMIT);
   assign dmag = dsat ? DUTY_LIMIT : q16;

   // serial unit request
   always_comb begin
      unit_req       = '0;
      unit_req.start = (state_ff == ST_ISSUE) && (step_ff != SP_ANG1) && (step_ff != SP_ANG2);
      unit_req.op    = OP_MUL;
      unit_req.n     = 5'd7;
      case (step_ff)
         SP_XX: begin
            unit_req.opa = OPA_W'(absx);
            unit_req.opb = OPB_W'(absx);
            unit_req.n   = 5'd17;
         end
         SP_YY: begin
            unit_req.opa = OPA_W'(absy);
            unit_req.opb = OPB_W'(absy);
            unit_req.n   = 5'd17;
         end
         SP_L1: begin
            unit_req.opa = OPA_W'(l1e);
            unit_req.opb = OPB_W'(l1e);
         end
         SP_L2: begin
            unit_req.opa = OPA_W'(l2e);
            unit_req.opb = OPB_W'(l2e);
         end
         SP_L3: begin
            unit_req.opa = OPA_W'(l3e);
            unit_req.opb = OPB_W'(l3e);
         end
         SP_DEN: begin
            unit_req.opa = OPA_W'(l1e);
            unit_req.opb = OPB_W'(l2e);
         end
         SP_CDIV: begin
            unit_req.op  = OP_DIV;
            unit_req.opa = OPA_W'(absnum) << 16;
            unit_req.opb = den_ff;
            unit_req.n   = 5'd17;
         end
         SP_CC: begin
            unit_req.opa = OPA_W'(cmag_ff);
            unit_req.opb = OPB_W'(cmag_ff);
            unit_req.n   = 5'd17;
         end
         SP_SQS: begin
            unit_req.op  = OP_SQRT;
            unit_req.opa = OPA_W'(sarg_ff);
            unit_req.n   = 5'd20;
         end
         SP_K1: begin
            unit_req.opa = OPA_W'(cmag_ff);
            unit_req.opb = OPB_W'(l3e);
         end
         SP_K2: begin
            unit_req.opa = OPA_W'(s_ff);
            unit_req.opb = OPB_W'(l3e);
         end
         SP_SQR: begin
            unit_req.op  = OP_SQRT;
            unit_req.opa = OPA_W'(rarg_ff);
            unit_req.n   = 5'd20;
         end
         SP_GEAR: begin
            unit_req.opa = OPA_W'(abstheta);
            unit_req.opb = OPB_W'(gear_ff);
            unit_req.n   = 5'd16;
         end
         SP_GAIN: begin
            unit_req.opa = OPA_W'(abse[47:0]);
            unit_req.opb = OPB_W'(gain_ff);
            unit_req.n   = 5'd16;
         end
         SP_SCALE: begin
            unit_req.opa = OPA_W'(unit_rsp.prod[63:0]);
            unit_req.opb = OPB_W'(DUTY_FACTOR);
            unit_req.n   = 5'd18;
         end
         SP_DDIV: begin
            unit_req.op  = OP_DIV;
            unit_req.opa = unit_rsp.prod;
            unit_req.opb = {dtm_ff, 16'd0};
            unit_req.n   = 5'd16;
         end
         default: begin
            unit_req.start = 1'b0;
         end
      endcase
   end

   // ---------------- CORDIC datapath ----------------
   assign sh_x  = cy_ff >>> ci_ff;
   assign sh_y  = cx_ff >>> ci_ff;
   assign tab   = 26'(fikd_atan_deg(5'(ci_ff)));
   assign cin_x = (step_ff == SP_ANG1) ? 26'(y_ff) : 26'(k1_ff);
   assign cin_y = (step_ff == SP_ANG1) ? {5'd0, r_ff} : {1'b0, k2_ff};
   assign xs0   = {{2{cin_x[25]}}, cin_x, 16'd0};
   assign ys0   = {3'd0, cin_y, 16'd0};
   assign z_fin = czero_ff ? 26'sd0 : cz_in;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      num_in   = num_ff;
      rarg_in  = rarg_ff;
      sarg_in  = sarg_ff;
      den_in   = den_ff;
      cmag_in  = cmag_ff;
      cneg_in  = cneg_ff;
      reach_in = reach_ff;
      s_in     = s_ff;
      k1_in    = k1_ff;
      k2_in    = k2_ff;
      r_in     = r_ff;
      z1_in    = z1_ff;
      theta_in = theta_ff;
      e_in     = e_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      ci_in    = ci_ff;
      czero_in = czero_ff;
      duty_in     = duty_ff;
      sat_in      = sat_ff;
      badout_in   = badout_ff;
      reachout_in = reachout_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // CORDIC step, also used for the final capture
      if (cy_ff > 44'sd0) begin
         cx_in = cx_ff + sh_x;
         cy_in = cy_ff - sh_y;
         cz_in = cz_ff + tab;
      end else begin
         cx_in = cx_ff - sh_x;
         cy_in = cy_ff + sh_y;
         cz_in = cz_ff - tab;
      end
      if (state_ff != ST_CORDIC) begin
         cx_in = cx_ff;
         cy_in = cy_ff;
         cz_in = cz_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
               step_in  = SP_XX;
            end
         end
         ST_ISSUE: begin
            if (step_ff == SP_ANG1 || step_ff == SP_ANG2) begin
               state_in = ST_CORDIC;
               ci_in    = '0;
               czero_in = (cin_x == 26'sd0) && (cin_y == 25'd0);
               if (xs0[43]) begin
                  // rotate by 90 degrees first
                  cx_in = ys0;
                  cy_in = 44'sd0 - xs0;
                  cz_in = 26'sd5898240;
               end else begin
                  cx_in = xs0;
                  cy_in = ys0;
                  cz_in = 26'sd0;
               end
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_CORDIC: begin
            ci_in = ci_ff + 1'b1;
            if (ci_ff == CIW'(CORDIC_STEPS - 1)) begin
               state_in = ST_ISSUE;
               step_in  = step_ff + 5'd1;
               if (step_ff == SP_ANG1) begin
                  z1_in = z_fin;
               end else begin
                  theta_in = {z1_ff[25], z1_ff} - {z_fin[25], z_fin};
               end
            end
         end
         ST_WAIT: begin
            if (unit_rsp.done) begin
               step_in  = step_ff + 5'd1;
               state_in = (step_ff == SP_DDIV) ? ST_DONE : ST_ISSUE;
               case (step_ff)
                  SP_XX: begin
                     num_in  = 42'(unit_rsp.prod[30:0]);
                     rarg_in = 40'(unit_rsp.prod[30:0]);
                  end
                  SP_YY: num_in = num_ff + 42'(unit_rsp.prod[30:0]);
                  SP_L1: begin
                     num_in  = num_ff + sq_shift;
                     rarg_in = rarg_ff + sq_shift[39:0];
                  end
                  SP_L2: num_in = num_ff - sq_shift;
                  SP_L3: num_in = num_ff - sq_shift;
                  SP_DEN: den_in = 48'(unit_rsp.prod[13:0]) << (2 * COORD_FRAC_BITS + 1);
                  SP_CDIV: begin
                     // cosine above one becomes 0, below minus one becomes -1
                     reach_in = c_over;
                     cneg_in  = num_ff[41];
                     if (c_over) begin
                        cmag_in = num_ff[41] ? 17'd65536 : 17'd0;
                     end else begin
                        cmag_in = q17;
                     end
                  end
                  SP_CC:  sarg_in = 40'h01_0000_0000 - 40'(unit_rsp.prod[33:0]);
                  SP_SQS: s_in = unit_rsp.quo[16:0];
                  SP_K1:  k1_in = cneg_ff ? ({2'b00, l2e, 16'd0} - kp)
                                          : ({2'b00, l2e, 16'd0} + kp);
                  SP_K2:  k2_in = unit_rsp.prod[23:0];
                  SP_SQR: r_in = unit_rsp.quo;
                  SP_GEAR: e_in = {{14{thm[34]}}, thm} - {enc_ff[31], enc_ff, 16'd0};
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               reachout_in  = reach_ff;
               badout_in    = bad_ff;
               sat_in       = !bad_ff && dsat;
               if (bad_ff) begin
                  duty_in = 16'sd0;
               end else begin
                  duty_in = e_ff[48] ? (16'd0 - dmag) : dmag;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= SP_XX;
         rsp_valid_ff  <= 1'b0;
         last_stamp_ff <= 32'd0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_valid && req_ready) begin
            last_stamp_ff <= req_stamp_us;
         end
      end
      if (req_valid && req_ready) begin
         x_ff   <= req_target_x;
         y_ff   <= req_target_y;
         enc_ff <= req_encoder_deg;
         dtm_ff <= req_stamp_us - last_stamp_ff;
         bad_ff <= req_stamp_us <= last_stamp_ff;
      end
      num_ff   <= num_in;
      rarg_ff  <= rarg_in;
      sarg_ff  <= sarg_in;
      den_ff   <= den_in;
      cmag_ff  <= cmag_in;
      cneg_ff  <= cneg_in;
      reach_ff <= reach_in;
      s_ff     <= s_in;
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      r_ff     <= r_in;
      z1_ff    <= z1_in;
      theta_ff <= theta_in;
      e_ff     <= e_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      ci_ff    <= ci_in;
      czero_ff <= czero_in;
      duty_ff     <= duty_in;
      sat_ff      <= sat_in;
      badout_ff   <= badout_in;
      reachout_ff <= reachout_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty_q8        = duty_ff;
   assign rsp_duty_saturated = sat_ff;
   assign rsp_bad_interval   = badout_ff;
   assign rsp_reach_clamped  = reachout_ff;

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("transaction accepted while the previous one is in flight");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_q8 <= 16'sd25600 && rsp_duty_q8 >= -16'sd25600))
      else $error("duty outside the saturation limits");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_interval) |-> (rsp_duty_q8 == 16'sd0 && !rsp_duty_saturated))
      else $error("bad interval with non-zero duty");

   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == ST_WAIT))
      else $error("serial unit finished outside its wait state");
`endif

endmodule

@@ dv/fikd_duty_checker.sv @@
// Checker for finger_ik_position_to_duty: mirrors the registers from the APB
// port, predicts the duty and flags of every accepted input transaction and
// compares them with the result transactions. Depends on fikd_pkg.
module fikd_duty_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic [31:0]        req_stamp_us,
   input  logic signed [31:0] req_encoder_deg,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_duty_q8,
   input  logic               rsp_duty_saturated,
   input  logic               rsp_bad_interval,
   input  logic               rsp_reach_clamped,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 duty_pending,
   output int                 fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fikd_pkg::*;

   typedef struct packed {
      logic signed [15:0] duty;
      logic               sat;
      logic               bad;
      logic               reach;
   } duty_result_type;

   localparam int FRAC  = FIKD_COORD_FRAC_BITS;
   localparam int STEPS = FIKD_CORDIC_STEPS;

   logic [6:0]  len_base, len_middle, len_tip;
   logic [15:0] gain, gear;
   logic [31:0] prev_stamp;
   duty_result_type duty_q[$];

   longint angle_table [0:23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
      1, 0};

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // vectoring CORDIC, result in degrees Q16
   function automatic longint vector_angle(longint yv, longint xv);
      longint xs, ys, z, t, dx, dy;
      z = 0;
      if (xv == 0 && yv == 0) return 0;
      xs = xv * 65536;
      ys = yv * 65536;
      if (xs < 0) begin
         t = xs;
         xs = ys;
         ys = -t;
         z = 90 * 65536;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys > 0) begin
            xs += dx; ys -= dy; z += angle_table[i];
         end else begin
            xs -= dx; ys += dy; z -= angle_table[i];
         end
      end
      return z;
   endfunction

   function automatic duty_result_type predict_duty(longint x, longint y, longint stamp,
                                                    longint enc, longint last);
      duty_result_type res;
      longint l1, l2, l3, l1f, l2f, l3f, num, den, c, s, k1, k2, r, theta, theta_m;
      longint e, dt, duty;
      longint unsigned mag, g, a, q;
      res = '0;
      duty = 0;
      l1 = (len_base == 0) ? 1 : len_base;
      l2 = (len_middle == 0) ? 1 : len_middle;
      l3 = (len_tip == 0) ? 1 : len_tip;
      l1f = l1 << FRAC;
      l2f = l2 << FRAC;
      l3f = l3 << FRAC;
      num = x * x + y * y + l1f * l1f - l2f * l2f - l3f * l3f;
      den = 2 * l1f * l2f;
      c = (num * 65536) / den;
      if (c > 65536) begin
         c = 0; res.reach = 1'b1;
      end else if (c < -65536) begin
         c = -65536; res.reach = 1'b1;
      end
      s = int_sqrt((64'd1 << 32) - c * c);
      k1 = l2 * 65536 + l3 * c;
      k2 = l3 * s;
      r = int_sqrt(x * x + l1f * l1f);
      theta = vector_angle(r, y) - vector_angle(k2, k1);
      theta_m = (theta * longint'(gear)) >>> 8;
      e = theta_m - enc * 65536;
      dt = stamp - last;
      if (dt <= 0) begin
         res.bad = 1'b1;
      end else begin
         mag = (e < 0) ? -e : e;
         g = gain;
         if (g != 0 && mag > 64'hFFFF_FFFF_FFFF_FFFF / g) begin
            res.sat = 1'b1;
         end else begin
            a = mag * g;
            if (a > 64'hFFFF_FFFF_FFFF_FFFF / DUTY_FACTOR) begin
               res.sat = 1'b1;
            end else begin
               q = (a * DUTY_FACTOR) / (longint'(dt) * 65536);
               if (q > DUTY_LIMIT) res.sat = 1'b1;
               else duty = q;
            end
         end
         if (res.sat) duty = DUTY_LIMIT;
         if (e < 0) duty = -duty;
      end
      res.duty = duty[15:0];
      return res;
   endfunction

   assign duty_pending = duty_q.size();

   always @(posedge clock) begin
      duty_result_type want;
      if (reset) begin
         len_base <= RST_BASE_LEN;
         len_middle <= RST_MIDDLE_LEN;
         len_tip <= RST_TIP_LEN;
         gain <= RST_GAIN;
         gear <= RST_GEAR;
         prev_stamp <= '0;
         duty_q.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_BASE_LEN:   len_base <= pwdata[6:0];
               REG_MIDDLE_LEN: len_middle <= pwdata[6:0];
               REG_TIP_LEN:    len_tip <= pwdata[6:0];
               REG_GAIN:       gain <= pwdata[15:0];
               REG_GEAR:       gear <= pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            duty_q.push_back(predict_duty(req_target_x, req_target_y, req_stamp_us,
                                          req_encoder_deg, prev_stamp));
            prev_stamp <= req_stamp_us;
         end
         if (rsp_valid && rsp_ready) begin
            if (duty_q.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = duty_q.pop_front();
               if (want.duty !== rsp_duty_q8 || want.sat !== rsp_duty_saturated ||
                   want.bad !== rsp_bad_interval || want.reach !== rsp_reach_clamped)
                  fail_count <= fail_count + 1;
               if (want.duty !== rsp_duty_q8)
                  $error("duty_q8 expected %0d got %0d", want.duty, rsp_duty_q8);
               if (want.sat !== rsp_duty_saturated)
                  $error("duty_saturated expected %0b got %0b", want.sat,
                         rsp_duty_saturated);
               if (want.bad !== rsp_bad_interval)
                  $error("bad_interval expected %0b got %0b", want.bad, rsp_bad_interval);
               if (want.reach !== rsp_reach_clamped)
                  $error("reach_clamped expected %0b got %0b", want.reach,
                         rsp_reach_clamped);
            end
         end
      end
   end

endmodule

@@ dv/finger_ik_position_to_duty_test.sv @@
// Testbench top for finger_ik_position_to_duty: clock, reset, APB register
// writes, input stimulus, random result stalls and the verdict.
// Depends on fikd_pkg, the block and fikd_duty_checker.
module finger_ik_position_to_duty_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fikd_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_target_x = '0;
   logic signed [15:0] req_target_y = '0;
   logic [31:0] req_stamp_us = '0;
   logic signed [31:0] req_encoder_deg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_duty_q8;
   logic rsp_duty_saturated, rsp_bad_interval, rsp_reach_clamped;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   int duty_pending, fail_count;
   int idle_cycles = 0;
   logic [31:0] stamp_now = '0;
   bit ready_free = 1'b0;

   always #5 clock = ~clock;

   finger_ik_position_to_duty dut (.*);
   fikd_duty_checker checker_i (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver stalls; stretches of always-ready come and go
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) ready_free <= ~ready_free;
      if (reset || ready_free) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 99) < 8) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 30) rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic send_item(logic [15:0] x, logic [15:0] y, logic [31:0] stamp,
                            logic [31:0] enc);
      int gap;
      req_target_x <= x; req_target_y <= y;
      req_stamp_us <= stamp; req_encoder_deg <= enc;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // lower valid and let every expected transaction drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (duty_pending != 0) @(posedge clock);
   endtask

   task automatic set_regs(logic [6:0] l1, logic [6:0] l2, logic [6:0] l3,
                           logic [15:0] g, logic [15:0] gr);
      settle();
      csr_write(REG_BASE_LEN, 32'(l1));
      csr_write(REG_MIDDLE_LEN, 32'(l2));
      csr_write(REG_TIP_LEN, 32'(l3));
      csr_write(REG_GAIN, 32'(g));
      csr_write(REG_GEAR, 32'(gr));
   endtask

   task automatic random_items(int count);
      logic [15:0] x, y;
      logic [31:0] enc, stamp;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            x = 16'($urandom_range(0, 40000) - 20000);
            y = 16'($urandom_range(0, 40000) - 20000);
         end else begin
            x = 16'($urandom); y = 16'($urandom);
         end
         r = $urandom_range(0, 99);
         if (r < 70) enc = $urandom_range(0, 800) - 400;
         else if (r < 90) enc = $urandom_range(0, 200000) - 100000;
         else enc = $urandom;
         r = $urandom_range(0, 99);
         if (r < 75) stamp = stamp_now + $urandom_range(1, 100000);
         else if (r < 85) stamp = stamp_now + $urandom_range(1, 2) * 32'd50000000;
         else if (r < 92) stamp = stamp_now - $urandom_range(0, 1000);
         else stamp = $urandom;
         stamp_now = stamp;
         if (i == count / 2) settle();
         send_item(x, y, stamp, enc);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // first item: stamp 0 against the cleared stored stamp
      send_item(16'sd0, 16'sd0, 32'd0, 32'sd0);
      send_item(16'sd0, 16'sd0, 32'd0, 32'sd0);
      send_item(16'h7FFF, 16'h7FFF, 32'd1000, 32'sd0);
      send_item(16'h8000, 16'h8000, 32'd2000, 32'sd0);
      send_item(16'h7FFF, 16'h8000, 32'd1999, 32'sd10);
      send_item(16'h8000, 16'h7FFF, 32'd1, 32'sh7FFF_FFFF);
      send_item(16'd5000, 16'd9000, 32'hFFFF_FFFF, 32'sh8000_0000);
      send_item(16'd5000, 16'd9000, 32'hFFFF_FFFF, 32'sd3);
      send_item(16'd12800, 16'd20000, 32'd0, 32'sd0);
      send_item(16'd12800, 16'd20000, 32'd1, 32'sd45);
      send_item(-16'sd12800, 16'd20000, 32'd100001, -32'sd45);
      send_item(16'd25000, -16'sd100, 32'd100002, 32'sd90);
      send_item(16'h5555, 16'hAAAA, 32'h5555_5555, 32'sh5555_5555);
      send_item(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'shAAAA_AAAA);
      stamp_now = 32'hAAAA_AAAA;
      random_items(250);
      // smallest links, zero gain and ratio: also a write outside the map
      set_regs(7'd1, 7'd1, 7'd1, 16'd0, 16'd0);
      csr_write(3'd7, 32'hFFFF_FFFF);
      send_item(16'd10, 16'd10, stamp_now + 5, 32'sd7);
      stamp_now = stamp_now + 5;
      random_items(240);
      // short base against long links drives the cosine below minus one
      set_regs(7'd1, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF);
      send_item(16'd0, 16'd0, stamp_now + 1, 32'sd0);
      send_item(16'd100, -16'sd100, stamp_now + 2, -32'sd1);
      stamp_now = stamp_now + 2;
      random_items(240);
      // zero lengths are taken as one
      set_regs(7'd0, 7'd0, 7'd0, 16'd256, 16'd384);
      random_items(240);
      set_regs(7'd127, 7'd127, 7'd127, 16'd1, 16'd1);
      random_items(130);
      set_regs(7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
               7'($urandom_range(1, 127)), 16'($urandom), 16'($urandom));
      random_items(130);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && duty_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/fikd_pkg.sv
sv/fikd_serial_unit.sv
sv/finger_ik_position_to_duty.sv
dv/fikd_duty_checker.sv
dv/finger_ik_position_to_duty_test.sv
